>>> rtl/delimited_frame_receiver_defines.svh
// ----------------------------------------------------------------------------
// Delimited frame receiver assertion macros
// Shared property wrappers for the port checker.
// ----------------------------------------------------------------------------
`ifndef DELIMITED_FRAME_RECEIVER_DEFINES_SVH
`define DELIMITED_FRAME_RECEIVER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define DFR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DFR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/dfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfr_pkg
// Types and constants shared by the delimited frame receiver modules.
// ----------------------------------------------------------------------------
package dfr_pkg;

    localparam int DFR_FRAME_CAPACITY = 64;
    localparam int HEADROOM           = 8;
    localparam int BYTE_W             = 8;
    localparam int COUNT_W            = 6;

    localparam logic [BYTE_W-1:0] CODE_CR = 8'h0D;
    localparam logic [BYTE_W-1:0] CODE_LF = 8'h0A;
    localparam logic [BYTE_W-1:0] CODE_NUL = 8'h00;

    localparam logic REG_START_MARKER = 1'b0;
    localparam logic REG_END_MARKER   = 1'b1;

    typedef struct packed {
        logic               bank;
        logic [COUNT_W-1:0] len;
    } dfr_desc_t;

    typedef struct packed {
        logic empty;
        logic full;
    } dfr_qstat_t;

endpackage

>>> rtl/delimited_frame_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delimited_frame_receiver
// Collects delimited byte frames and replays each completed frame as a run.
// ----------------------------------------------------------------------------
// Input channel: one rx_byte per beat on in_valid/in_ready. A front end
// tracks framing and writes each frame into one of two RAM banks.
// Output channel: one beat per stored byte on out_valid/out_ready, with
// byte_index, frame_length and last on the final beat.
// Configuration: cfg_write/cfg_index/cfg_data, index 0 start marker,
// index 1 end marker; write only while the block is idle.
// Input accepts one byte per cycle while in_ready is high. A closing byte
// pushes a descriptor into the queue; the back end leaves idle and issues a
// registered RAM read ahead of every beat, so beats are never back to back.
// Two completed frames may be pending; with both banks full in_ready drops
// until the back end releases the older bank on its last beat.
// Output stalls hold the current beat and do not block input until both
// banks are full.
// Reset: idle, queue empty, start marker 0, end marker 0x0D. No RAM clear.
// ----------------------------------------------------------------------------
module delimited_frame_receiver import dfr_pkg::*; #(
    parameter int FRAME_CAPACITY = DFR_FRAME_CAPACITY
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic               cfg_index,
    input  logic [BYTE_W-1:0]  cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [BYTE_W-1:0]  rx_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [BYTE_W-1:0]  data_byte,
    output logic [COUNT_W-1:0] byte_index,
    output logic [COUNT_W-1:0] frame_length,
    output logic               last
);

    localparam int STORE_DEPTH = FRAME_CAPACITY - HEADROOM;
    localparam int INDEX_W     = $clog2(STORE_DEPTH);
    localparam int RAM_DEPTH   = 2 ** (INDEX_W + 1);

    logic              mem_we;
    logic [INDEX_W:0]  mem_waddr;
    logic [BYTE_W-1:0] mem_wdata;
    logic              mem_re;
    logic [INDEX_W:0]  mem_raddr;
    logic [BYTE_W-1:0] mem_rdata;
    logic              push;
    logic              pop;
    dfr_desc_t         push_desc;
    dfr_desc_t         head;
    dfr_qstat_t        qstat;

    dfr_front #(
        .FRAME_CAPACITY (FRAME_CAPACITY),
        .INDEX_W        (INDEX_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_byte   (rx_byte),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .push      (push),
        .push_desc (push_desc),
        .qstat     (qstat)
    );

    dfr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .head      (head),
        .qstat     (qstat)
    );

    dfr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    dfr_back #(
        .INDEX_W (INDEX_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .qstat        (qstat),
        .pop          (pop),
        .mem_re       (mem_re),
        .mem_raddr    (mem_raddr),
        .mem_rdata    (mem_rdata),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .data_byte    (data_byte),
        .byte_index   (byte_index),
        .frame_length (frame_length),
        .last         (last)
    );

endmodule

>>> rtl/dfr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfr_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module dfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/dfr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfr_front
// Accepts bytes, tracks framing, writes the frame into the current bank and
// pushes a descriptor when a frame completes.
// ----------------------------------------------------------------------------
module dfr_front import dfr_pkg::*; #(
    parameter int FRAME_CAPACITY = DFR_FRAME_CAPACITY,
    parameter int INDEX_W        = 6
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic                 cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [BYTE_W-1:0]    rx_byte,
    output logic                 mem_we,
    output logic [INDEX_W:0]     mem_waddr,
    output logic [BYTE_W-1:0]    mem_wdata,
    output logic                 push,
    output dfr_desc_t            push_desc,
    input  dfr_qstat_t           qstat
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_FRAME,
        PH_CR
    } phase_t;

    localparam logic [COUNT_W:0] LIMIT = (COUNT_W+1)'(FRAME_CAPACITY - HEADROOM);

    phase_t             phase_reg, phase_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               bank_reg, bank_next;
    logic [BYTE_W-1:0]  start_marker_reg;
    logic [BYTE_W-1:0]  end_marker_reg;
    logic [COUNT_W-1:0] cnt_inc;
    logic               accept;
    logic               opens;
    logic               complete;

    assign in_ready  = !qstat.full;
    assign accept    = in_valid && in_ready;
    assign cnt_inc   = count_reg + COUNT_W'(1);
    assign opens     = (start_marker_reg == CODE_NUL) ? (rx_byte != CODE_NUL)
                                                      : (rx_byte == start_marker_reg);
    assign mem_waddr = {bank_reg, count_reg[INDEX_W-1:0]};
    assign mem_wdata = rx_byte;
    assign push_desc = '{bank: bank_reg, len: cnt_inc};

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        bank_next  = bank_reg;
        mem_we     = 1'b0;
        push       = 1'b0;
        complete   = 1'b0;
        if (accept)
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (opens)
                    begin
                        mem_we     = 1'b1;
                        count_next = COUNT_W'(1);
                        phase_next = PH_FRAME;
                    end
                end
                default:
                begin
                    mem_we = 1'b1;
                    if ({1'b0, cnt_inc} >= LIMIT)
                    begin
                        phase_next = PH_IDLE;
                        count_next = '0;
                    end
                    else if (rx_byte == end_marker_reg)
                    begin
                        if (end_marker_reg == CODE_CR)
                        begin
                            phase_next = PH_CR;
                            count_next = cnt_inc;
                        end
                        else
                        begin
                            complete = 1'b1;
                        end
                    end
                    else if (phase_reg == PH_CR && rx_byte == CODE_LF)
                    begin
                        complete = 1'b1;
                    end
                    else
                    begin
                        count_next = cnt_inc;
                    end
                    if (complete)
                    begin
                        phase_next = PH_IDLE;
                        count_next = '0;
                        // a length that wrapped to zero is not pushed: no frame is sent
                        if (cnt_inc != '0)
                        begin
                            push      = 1'b1;
                            bank_next = !bank_reg;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            count_reg        <= '0;
            bank_reg         <= 1'b0;
            start_marker_reg <= CODE_NUL;
            end_marker_reg   <= CODE_CR;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            bank_reg  <= bank_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_START_MARKER: start_marker_reg <= cfg_data;
                    REG_END_MARKER:   end_marker_reg   <= cfg_data;
                    default:          ;
                endcase
            end
        end
    end

endmodule

>>> rtl/dfr_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfr_queue
// Two-entry descriptor queue between the front and the back end; one entry
// per frame bank.
// ----------------------------------------------------------------------------
module dfr_queue import dfr_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  dfr_desc_t  push_desc,
    input  logic       pop,
    output dfr_desc_t  head,
    output dfr_qstat_t qstat
);

    dfr_desc_t  entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign head        = entry_reg[rd_ptr_reg];
    assign qstat.empty = (count_reg == 2'd0);
    assign qstat.full  = (count_reg == 2'd2);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: ;
            endcase
        end
    end

endmodule

>>> rtl/dfr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfr_back
// Drains a completed frame from its bank, one beat per stored byte, and
// releases the queue entry on the last beat.
// ----------------------------------------------------------------------------
module dfr_back import dfr_pkg::*; #(
    parameter int INDEX_W = 6
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dfr_desc_t            head,
    input  dfr_qstat_t           qstat,
    output logic                 pop,
    output logic                 mem_re,
    output logic [INDEX_W:0]     mem_raddr,
    input  logic [BYTE_W-1:0]    mem_rdata,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [BYTE_W-1:0]    data_byte,
    output logic [COUNT_W-1:0]   byte_index,
    output logic [COUNT_W-1:0]   frame_length,
    output logic                 last
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_OUT
    } state_t;

    state_t             state_reg;
    logic [COUNT_W-1:0] idx_reg;
    logic               out_valid_reg;
    logic               last_reg;

    assign mem_re       = (state_reg == S_READ);
    assign mem_raddr    = {head.bank, idx_reg[INDEX_W-1:0]};
    assign pop          = (state_reg == S_OUT) && out_ready && last_reg;
    assign out_valid    = out_valid_reg;
    assign data_byte    = mem_rdata;
    assign byte_index   = idx_reg;
    assign frame_length = head.len;
    assign last         = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (!qstat.empty)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    last_reg      <= ((idx_reg + COUNT_W'(1)) == head.len);
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                        if (last_reg)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + COUNT_W'(1);
                            state_reg <= S_READ;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> rtl/dfr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfr_checker
// Port-level checks on the output run of the frame receiver.
// ----------------------------------------------------------------------------
`include "delimited_frame_receiver_defines.svh"

module dfr_checker import dfr_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [BYTE_W-1:0]  data_byte,
    input  logic [COUNT_W-1:0] byte_index,
    input  logic [COUNT_W-1:0] frame_length,
    input  logic               last
);

    `DFR_ASSERT_NOW(a_index_in_frame, out_valid, byte_index < frame_length, "index past length")
    `DFR_ASSERT_NOW(a_last_at_end, out_valid && last, byte_index == frame_length - 6'd1, "last misplaced")
    `DFR_ASSERT_NEXT(a_length_steady, out_valid && out_ready && !last, $stable(frame_length), "length changed in run")
    `DFR_ASSERT_NEXT(a_beat_held, out_valid && !out_ready, out_valid && $stable(data_byte), "stalled beat dropped")

endmodule

bind delimited_frame_receiver dfr_checker u_dfr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .data_byte    (data_byte),
    .byte_index   (byte_index),
    .frame_length (frame_length),
    .last         (last)
);

>>> verif/dfr_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfr_frame_checker
// Watches the config port and both channels of the delimited frame receiver.
// Tracks the framing state from every accepted input beat, queues the beats
// each completed frame should replay, and compares every output beat with
// the oldest queued one. Reports the mismatch count, pending beats and framing state.
// ----------------------------------------------------------------------------
module dfr_frame_checker import dfr_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic               cfg_index,
    input  logic [BYTE_W-1:0]  cfg_data,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [BYTE_W-1:0]  rx_byte,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [BYTE_W-1:0]  data_byte,
    input  logic [COUNT_W-1:0] byte_index,
    input  logic [COUNT_W-1:0] frame_length,
    input  logic               last,
    output int                 mismatch_count,
    output int                 beats_due,
    output logic               frame_open,
    output logic               cr_seen
);

    localparam int DROP_COUNT = DFR_FRAME_CAPACITY - HEADROOM;
    localparam int REPORT_MAX = 10;

    typedef enum logic [1:0] {
        RX_IDLE,
        RX_BODY,
        RX_AFTER_CR
    } rx_phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  data;
        logic [COUNT_W-1:0] pos;
        logic [COUNT_W-1:0] length;
        logic               is_last;
    } frame_beat_t;

    logic [BYTE_W-1:0]  open_marker;
    logic [BYTE_W-1:0]  close_marker;
    rx_phase_t          rx_phase;
    logic [COUNT_W-1:0] held_count;
    logic [BYTE_W-1:0]  held_bytes [DFR_FRAME_CAPACITY];
    frame_beat_t        beat_queue [$];

    task automatic release_frame;
        frame_beat_t b;
        for (int k = 0; k < held_count; k++)
        begin
            b.data    = held_bytes[k];
            b.pos     = COUNT_W'(k);
            b.length  = held_count;
            b.is_last = (k == held_count - 1);
            beat_queue.push_back(b);
        end
        rx_phase   = RX_IDLE;
        held_count = '0;
    endtask

    task automatic take_rx_byte(input logic [BYTE_W-1:0] b);
        logic opens;
        if (rx_phase == RX_IDLE)
        begin
            opens = (open_marker == CODE_NUL) ? (b != CODE_NUL) : (b == open_marker);
            if (opens)
            begin
                held_bytes[0] = b;
                held_count    = 1;
                rx_phase      = RX_BODY;
            end
        end
        else
        begin
            held_bytes[held_count] = b;
            held_count++;
            if (held_count >= DROP_COUNT)
            begin
                // overflow: frame dropped, this byte has no other effect
                rx_phase   = RX_IDLE;
                held_count = '0;
            end
            else if (b == close_marker)
            begin
                if (close_marker == CODE_CR)
                    rx_phase = RX_AFTER_CR;
                else
                    release_frame();
            end
            else if (rx_phase == RX_AFTER_CR && b == CODE_LF)
            begin
                release_frame();
            end
        end
    endtask

    task automatic check_beat;
        frame_beat_t want;
        if (beat_queue.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
                $display("%0t: beat with nothing pending: data %h index %0d length %0d last %b",
                         $time, data_byte, byte_index, frame_length, last);
        end
        else
        begin
            want = beat_queue.pop_front();
            if (want.data !== data_byte || want.pos !== byte_index ||
                want.length !== frame_length || want.is_last !== last)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display({"%0t: beat mismatch: want data %h index %0d length %0d last %b,",
                              " got data %h index %0d length %0d last %b"},
                             $time, want.data, want.pos, want.length, want.is_last,
                             data_byte, byte_index, frame_length, last);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_marker    = CODE_NUL;
            close_marker   = CODE_CR;
            rx_phase       = RX_IDLE;
            held_count     = '0;
            mismatch_count = 0;
            beat_queue.delete();
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == REG_START_MARKER)
                    open_marker = cfg_data;
                else if (cfg_index == REG_END_MARKER)
                    close_marker = cfg_data;
            end
            if (out_valid && out_ready)
                check_beat();
            if (in_valid && in_ready)
                take_rx_byte(rx_byte);
        end
        beats_due  = beat_queue.size();
        frame_open = (rx_phase != RX_IDLE);
        cr_seen    = (rx_phase == RX_AFTER_CR);
    end

endmodule

>>> verif/delimited_frame_receiver_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delimited_frame_receiver_test
// Drives byte streams into the delimited frame receiver: directed framing
// corners, capacity edge frames, then randomized frames and noise under
// several marker settings and sender/receiver idle mixes. A checker module
// predicts and compares the replayed frames; this top gives the verdict.
// ----------------------------------------------------------------------------
module delimited_frame_receiver_test;

    import dfr_pkg::*;

    localparam int QUIET_LIMIT = 3000;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cfg_write = 1'b0;
    logic               cfg_index = REG_START_MARKER;
    logic [BYTE_W-1:0]  cfg_data  = '0;
    logic               in_valid  = 1'b0;
    logic [BYTE_W-1:0]  rx_byte   = '0;
    logic               out_ready = 1'b0;
    logic               in_ready;
    logic               out_valid;
    logic [BYTE_W-1:0]  data_byte;
    logic [COUNT_W-1:0] byte_index;
    logic [COUNT_W-1:0] frame_length;
    logic               last;

    int                 mismatch_count;
    int                 beats_due;
    logic               frame_open;
    logic               cr_seen;

    int                 idle_pct     = 0;
    int                 stall_pct    = 0;
    int                 quiet_cycles = 0;
    int                 bytes_sent   = 0;
    logic [BYTE_W-1:0]  start_now    = CODE_NUL;
    logic [BYTE_W-1:0]  end_now      = CODE_CR;

    initial
    begin
        forever #5 clk = ~clk;
    end

    delimited_frame_receiver u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .data_byte    (data_byte),
        .byte_index   (byte_index),
        .frame_length (frame_length),
        .last         (last)
    );

    dfr_frame_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .data_byte      (data_byte),
        .byte_index     (byte_index),
        .frame_length   (frame_length),
        .last           (last),
        .mismatch_count (mismatch_count),
        .beats_due      (beats_due),
        .frame_open     (frame_open),
        .cr_seen        (cr_seen)
    );

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    // any byte that neither closes the frame nor completes a CR LF ending
    function automatic logic [BYTE_W-1:0] body_byte();
        logic [BYTE_W-1:0] b;
        do
            b = BYTE_W'($urandom_range(255));
        while (b == end_now || (end_now == CODE_CR && b == CODE_LF));
        return b;
    endfunction

    // total counts the opener and the ending, CR LF counted as two
    task automatic send_frame(input int total);
        int body;
        body = (end_now == CODE_CR) ? total - 3 : total - 2;
        if (body < 0)
            body = 0;
        send_byte((start_now == CODE_NUL) ? BYTE_W'($urandom_range(255, 1)) : start_now);
        repeat (body)
            send_byte(body_byte());
        if (end_now == CODE_CR)
        begin
            send_byte(CODE_CR);
            if (total < 50 && $urandom_range(3) == 0)
                repeat ($urandom_range(3, 1))
                    send_byte(body_byte());
            send_byte(CODE_LF);
        end
        else
            send_byte(end_now);
    endtask

    task automatic write_markers(input logic [BYTE_W-1:0] s, input logic [BYTE_W-1:0] e);
        cfg_write <= 1'b1;
        cfg_index <= REG_START_MARKER;
        cfg_data  <= s;
        @(posedge clk);
        cfg_index <= REG_END_MARKER;
        cfg_data  <= e;
        @(posedge clk);
        cfg_write <= 1'b0;
        start_now = s;
        end_now   = e;
    endtask

    // close any open frame, drain the output and let the pipeline go quiet
    task automatic settle;
        in_valid <= 1'b0;
        @(posedge clk);
        while (frame_open)
        begin
            if (end_now == CODE_CR)
                send_byte(cr_seen ? CODE_LF : CODE_CR);
            else
                send_byte(end_now);
            in_valid <= 1'b0;
            @(posedge clk);
        end
        while (beats_due != 0)
            @(posedge clk);
        repeat (12)
            @(posedge clk);
    endtask

    task automatic run_traffic(input int n);
        int target;
        int r;
        target = bytes_sent + n;
        while (bytes_sent < target)
        begin
            r = $urandom_range(99);
            if (r < 12)
                repeat ($urandom_range(4, 1))
                    send_byte(BYTE_W'($urandom));
            else if (r < 16)
                send_frame($urandom_range(58, 50));
            else
                send_frame($urandom_range(14, 2));
        end
    endtask

    task automatic run_phase(input logic [BYTE_W-1:0] s, input logic [BYTE_W-1:0] e,
                             input int idle, input int stall, input int n);
        settle();
        write_markers(s, e);
        idle_pct  = idle;
        stall_pct = stall;
        run_traffic(n);
    endtask

    initial
    begin
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset markers: any nonzero opens, CR LF ends
        send_byte(CODE_NUL);
        send_byte(8'hFF);
        send_byte(CODE_LF);
        send_byte(CODE_CR);
        send_byte(8'h55);
        send_byte(CODE_LF);
        // CR as opener is not an ending; stray byte between CR and LF
        send_byte(CODE_CR);
        send_byte(CODE_LF);
        send_byte(CODE_NUL);
        send_byte(CODE_CR);
        send_byte(8'h31);
        send_byte(CODE_LF);
        // longest frame, then LF landing on the overflow byte
        send_frame(DFR_FRAME_CAPACITY - HEADROOM - 1);
        send_frame(DFR_FRAME_CAPACITY - HEADROOM);

        settle();
        write_markers(8'h7E, 8'h7E);
        send_byte(8'h41);
        send_byte(8'h7E);
        send_byte(8'h7E);
        send_byte(8'h7E);
        send_byte(CODE_NUL);
        send_byte(8'hFF);
        send_byte(8'h7E);

        settle();
        write_markers(8'hFF, CODE_NUL);
        send_byte(CODE_NUL);
        send_byte(8'hFF);
        send_byte(CODE_NUL);

        run_phase(CODE_NUL, CODE_CR, 0, 0, 20);
        run_phase(8'hFF, CODE_NUL, 49, 0, 20);
        run_phase(CODE_NUL, 8'hFF, 0, 49, 20);
        run_phase(8'h7E, 8'h7E, 27, 27, 20);
        run_phase(BYTE_W'($urandom_range(255, 1)), CODE_CR, 49, 0, 20);
        run_phase(BYTE_W'($urandom), BYTE_W'($urandom), 27, 27, 20);
        run_phase(CODE_NUL, CODE_CR, 0, 0, 15);
        settle();

        if (mismatch_count == 0 && beats_due == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
